FILE: hw/rtl/vpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpd_pkg
// Shared types and constants of the vector pair distance block.
// ----------------------------------------------------------------------------
package vpd_pkg;

  // widths of the accumulators and results
  localparam int unsigned AccW  = 48;
  localparam int unsigned DistW = 32;
  localparam int unsigned RootW = 32;
  localparam int unsigned QuoW  = 17;

  // metric register codes; the unused code falls back to squared euclidean
  localparam logic [1:0] MODE_EUCLID   = 2'd0;
  localparam logic [1:0] MODE_COSINE   = 2'd1;
  localparam logic [1:0] MODE_SQEUCLID = 2'd2;

  // accumulator select codes
  localparam logic [1:0] SEL_DD = 2'd0;
  localparam logic [1:0] SEL_AA = 2'd1;
  localparam logic [1:0] SEL_BB = 2'd2;
  localparam logic [1:0] SEL_AB = 2'd3;

  // Q16.16 constants
  localparam logic [DistW-1:0] DIST_TWO = 32'h0002_0000;
  localparam logic [QuoW-1:0]  QUO_ONE  = 17'h1_0000;

  // saturation limits
  localparam logic [AccW-1:0] ACC_UMAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [AccW-1:0] ACC_SMAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [AccW-1:0] ACC_SMIN = 48'h8000_0000_0000;

  // control from the sequencer to the accumulator datapath
  typedef struct packed {
    logic       mul_en;
    logic       add_en;
    logic [1:0] sel;
    logic       clear;
  } acc_ctrl_t;

endpackage

FILE: hw/rtl/vpd_acc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpd_acc
// Shared multiplier and saturating adders feeding the four accumulators.
// ----------------------------------------------------------------------------
module vpd_acc (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  vpd_pkg::acc_ctrl_t         ctrl_i,
  input  logic signed [15:0]         elem_a_i,
  input  logic signed [15:0]         elem_b_i,
  output logic [vpd_pkg::AccW-1:0]   sum_sq_diff_o,
  output logic [vpd_pkg::AccW-1:0]   sum_aa_o,
  output logic [vpd_pkg::AccW-1:0]   sum_bb_o,
  output logic [vpd_pkg::AccW-1:0]   sum_ab_o,
  output logic                       overflow_o
);
  import vpd_pkg::*;

  logic signed [16:0] diff, op_x, op_y;
  logic signed [33:0] prod_q;
  logic [AccW-1:0]    sq_q, aa_q, bb_q, ab_q;
  logic               ovf_q;
  logic [AccW-1:0]    uacc;
  logic [AccW:0]      usum, ssum;
  logic               usat, ssat;
  logic [AccW-1:0]    unew, snew;

  // operand select for the shared multiplier
  assign diff = {elem_a_i[15], elem_a_i} - {elem_b_i[15], elem_b_i};

  always_comb begin
    unique case (ctrl_i.sel)
      SEL_DD: begin
        op_x = diff;
        op_y = diff;
      end
      SEL_AA: begin
        op_x = {elem_a_i[15], elem_a_i};
        op_y = {elem_a_i[15], elem_a_i};
      end
      SEL_BB: begin
        op_x = {elem_b_i[15], elem_b_i};
        op_y = {elem_b_i[15], elem_b_i};
      end
      default: begin
        op_x = {elem_a_i[15], elem_a_i};
        op_y = {elem_b_i[15], elem_b_i};
      end
    endcase
  end

  // unsigned saturating add for the squared sums
  always_comb begin
    unique case (ctrl_i.sel)
      SEL_DD:  uacc = sq_q;
      SEL_AA:  uacc = aa_q;
      default: uacc = bb_q;
    endcase
    usum = {1'b0, uacc} + {16'd0, prod_q[32:0]};
    usat = usum[AccW];
    unew = usat ? ACC_UMAX : usum[AccW-1:0];
  end

  // signed saturating add for the cross sum
  always_comb begin
    ssum = {ab_q[AccW-1], ab_q} + {{15{prod_q[33]}}, prod_q};
    ssat = ssum[AccW] ^ ssum[AccW-1];
    if (ssat) begin
      snew = ssum[AccW] ? ACC_SMIN : ACC_SMAX;
    end else begin
      snew = ssum[AccW-1:0];
    end
  end

  // product register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= op_x * op_y;
    end
  end

  // accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q  <= '0;
      aa_q  <= '0;
      bb_q  <= '0;
      ab_q  <= '0;
      ovf_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      sq_q  <= '0;
      aa_q  <= '0;
      bb_q  <= '0;
      ab_q  <= '0;
      ovf_q <= 1'b0;
    end else if (ctrl_i.add_en) begin
      unique case (ctrl_i.sel)
        SEL_DD: begin
          sq_q  <= unew;
          ovf_q <= ovf_q | usat;
        end
        SEL_AA: begin
          aa_q  <= unew;
          ovf_q <= ovf_q | usat;
        end
        SEL_BB: begin
          bb_q  <= unew;
          ovf_q <= ovf_q | usat;
        end
        default: begin
          ab_q  <= snew;
          ovf_q <= ovf_q | ssat;
        end
      endcase
    end
  end

  assign sum_sq_diff_o = sq_q;
  assign sum_aa_o      = aa_q;
  assign sum_bb_o      = bb_q;
  assign sum_ab_o      = ab_q;
  assign overflow_o    = ovf_q;

endmodule

FILE: hw/rtl/vpd_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpd_sqrt
// Integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module vpd_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [63:0]               x_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [vpd_pkg::RootW-1:0] root_o
);
  import vpd_pkg::*;

  localparam logic [4:0] CntLast = 5'(RootW - 1);

  logic [63:0]      x_q;
  logic [RootW+1:0] rem_q;
  logic [RootW-1:0] root_q;
  logic [4:0]       cnt_q;
  logic             busy_q, done_q;
  logic [RootW+3:0] rem_sh, trial, rem_nxt;
  logic             ge;

  // one restoring step: bring down two bits, try subtracting 4*root+1
  assign rem_sh  = {rem_q, x_q[63:62]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_nxt = ge ? rem_sh - trial : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      x_q    <= x_i;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= CntLast;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      x_q    <= {x_q[61:0], 2'b00};
      rem_q  <= rem_nxt[RootW+1:0];
      root_q <= {root_q[RootW-2:0], ge};
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 5'd1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: hw/rtl/vpd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpd_div
// Fraction num * 2^32 / den, one quotient bit per cycle, clamped to 1.0.
// ----------------------------------------------------------------------------
module vpd_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [vpd_pkg::AccW-1:0]  num_i,
  input  logic [63:0]               den_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [vpd_pkg::QuoW-1:0]  quo_o
);
  import vpd_pkg::*;

  logic [63:0]     rem_q, den_q;
  logic [31:0]     q_q, q_nxt;
  logic [QuoW-1:0] quo_q;
  logic [4:0]      cnt_q;
  logic            busy_q, done_q;
  logic [64:0]     rem_sh, rem_nxt;
  logic            ge, whole;

  // a numerator at or above the divisor is already at least 1.0
  assign whole = {16'd0, num_i} >= den_i;

  // restoring step
  assign rem_sh  = {rem_q, 1'b0};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_nxt = ge ? rem_sh - {1'b0, den_q} : rem_sh;
  assign q_nxt   = {q_q[30:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      den_q  <= '0;
      q_q    <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      rem_q <= {16'd0, num_i};
      den_q <= den_i;
      q_q   <= '0;
      cnt_q <= 5'd31;
      if (whole) begin
        quo_q  <= QUO_ONE;
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
      end
    end else if (busy_q) begin
      rem_q <= rem_nxt[63:0];
      q_q   <= q_nxt;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
        quo_q  <= (q_nxt > {15'd0, QUO_ONE}) ? QUO_ONE : q_nxt[QuoW-1:0];
      end else begin
        cnt_q <= cnt_q - 5'd1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: hw/rtl/vector_pair_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_pair_distance
// Euclidean, cosine and squared euclidean distance over a stream of pairs.
// ----------------------------------------------------------------------------
// Each pair is taken in an accept state, then four products pass in turn
// through one shared multiplier and the saturating adders, each in a multiply
// and an add state. The last pair then finishes through the bit-serial root
// unit (euclidean) or root and divide units (cosine with nonzero norms), plus
// any wait for an unread result; ready is low meanwhile. Reset (async, low)
// clears control and the accumulators and selects euclidean.
module vector_pair_distance (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: metric_mode
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] elem_a, [31:16] elem_b
  input  logic        s_axis_tlast,   // last_elem
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] distance
  output logic        m_axis_tuser    // [0] saturated
);
  import vpd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ADD, S_FIN, S_SQ_E, S_SQ_A, S_SQ_B,
    S_PROD, S_DIVS, S_DIVW, S_EMIT
  } state_e;

  state_e              state_q;
  logic [1:0]          mode_q, sel_q;
  logic signed [15:0]  a_q, b_q;
  logic                last_q;
  logic [RootW-1:0]    na_q, nb_q;
  logic [63:0]         p_q, sqrt_x_q;
  logic                sqrt_start_q, div_start_q;
  logic [DistW-1:0]    dist_q, out_data_q;
  logic                clamp_q, out_valid_q, out_sat_q;

  acc_ctrl_t           acc_ctrl;
  logic [AccW-1:0]     sum_sq, sum_aa, sum_bb, sum_ab, mag;
  logic                ovf;
  logic                sqrt_busy, sqrt_done, div_busy, div_done;
  logic [RootW-1:0]    root;
  logic [QuoW-1:0]     quo;
  logic [DistW-1:0]    twice_quo;
  logic                out_load;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_EUCLID;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // datapath control
  assign out_load = (state_q == S_EMIT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    acc_ctrl.mul_en = (state_q == S_MUL);
    acc_ctrl.add_en = (state_q == S_ADD);
    acc_ctrl.sel    = sel_q;
    acc_ctrl.clear  = out_load;
  end

  vpd_acc u_acc (
    .clk_i,
    .rst_ni,
    .ctrl_i        (acc_ctrl),
    .elem_a_i      (a_q),
    .elem_b_i      (b_q),
    .sum_sq_diff_o (sum_sq),
    .sum_aa_o      (sum_aa),
    .sum_bb_o      (sum_bb),
    .sum_ab_o      (sum_ab),
    .overflow_o    (ovf)
  );

  vpd_sqrt u_sqrt (
    .clk_i,
    .rst_ni,
    .start_i (sqrt_start_q),
    .x_i     (sqrt_x_q),
    .busy_o  (sqrt_busy),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // magnitude of the cross sum
  assign mag = sum_ab[AccW-1] ? (~sum_ab + 48'd1) : sum_ab;

  vpd_div u_div (
    .clk_i,
    .rst_ni,
    .start_i (div_start_q),
    .num_i   (mag),
    .den_i   (p_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign twice_quo = {14'd0, quo, 1'b0};

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      sel_q        <= SEL_DD;
      a_q          <= '0;
      b_q          <= '0;
      last_q       <= 1'b0;
      na_q         <= '0;
      nb_q         <= '0;
      p_q          <= '0;
      sqrt_x_q     <= '0;
      sqrt_start_q <= 1'b0;
      div_start_q  <= 1'b0;
      dist_q       <= '0;
      clamp_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      out_sat_q    <= 1'b0;
    end else begin
      // result register: load a finished result or drop one that was taken
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_data_q  <= dist_q;
        out_sat_q   <= ovf | clamp_q;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            a_q     <= s_axis_tdata[15:0];
            b_q     <= s_axis_tdata[31:16];
            last_q  <= s_axis_tlast;
            sel_q   <= SEL_DD;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          state_q <= S_ADD;
        end
        S_ADD: begin
          if (sel_q == SEL_AB) begin
            state_q <= last_q ? S_FIN : S_IDLE;
          end else begin
            sel_q   <= sel_q + 2'd1;
            state_q <= S_MUL;
          end
        end
        S_FIN: begin
          unique case (mode_q)
            MODE_EUCLID: begin
              clamp_q      <= 1'b0;
              sqrt_x_q     <= {sum_sq, 16'd0};
              sqrt_start_q <= 1'b1;
              state_q      <= S_SQ_E;
            end
            MODE_COSINE: begin
              clamp_q <= 1'b0;
              if (sum_aa == '0 || sum_bb == '0) begin
                dist_q  <= DIST_TWO;
                state_q <= S_EMIT;
              end else begin
                sqrt_x_q     <= {sum_aa, 16'd0};
                sqrt_start_q <= 1'b1;
                state_q      <= S_SQ_A;
              end
            end
            default: begin
              clamp_q <= |sum_sq[AccW-1:DistW];
              dist_q  <= (|sum_sq[AccW-1:DistW]) ? '1 : sum_sq[DistW-1:0];
              state_q <= S_EMIT;
            end
          endcase
        end
        S_SQ_E: begin
          sqrt_start_q <= 1'b0;
          if (sqrt_done) begin
            dist_q  <= root;
            state_q <= S_EMIT;
          end
        end
        S_SQ_A: begin
          sqrt_start_q <= sqrt_done;
          if (sqrt_done) begin
            na_q     <= root;
            sqrt_x_q <= {sum_bb, 16'd0};
            state_q  <= S_SQ_B;
          end
        end
        S_SQ_B: begin
          sqrt_start_q <= 1'b0;
          if (sqrt_done) begin
            nb_q    <= root;
            state_q <= S_PROD;
          end
        end
        S_PROD: begin
          p_q     <= na_q * nb_q;
          state_q <= S_DIVS;
        end
        S_DIVS: begin
          div_start_q <= 1'b1;
          state_q     <= S_DIVW;
        end
        S_DIVW: begin
          div_start_q <= 1'b0;
          if (div_done) begin
            dist_q  <= sum_ab[AccW-1] ? DIST_TWO + twice_quo : DIST_TWO - twice_quo;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sat_q;

  // the root unit is never restarted mid-run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_start_q |-> !sqrt_busy)
    else $error("sqrt restarted while busy");

  // the divide unit is never restarted mid-run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_q |-> !div_busy)
    else $error("divide restarted while busy");

  // an accepted transaction always starts the product sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q == S_MUL && sel_q == SEL_DD)
    else $error("accepted pair did not start accumulation");

  // accumulators are empty right after a result is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> sum_sq == '0 && sum_ab == '0 && !ovf)
    else $error("accumulators not cleared after result");

endmodule
